@@ hw/rtl/itp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg
// Shared constants, types and helpers for the infix-to-prefix operator stack.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  localparam logic [2:0] KIND_OPND  = 3'd0;
  localparam logic [2:0] KIND_LPAR  = 3'd1;
  localparam logic [2:0] KIND_RPAR  = 3'd2;
  localparam logic [2:0] KIND_CARET = 3'd3;
  localparam logic [2:0] KIND_OP    = 3'd4;

  localparam logic [1:0] SRC_CHAR = 2'd0;
  localparam logic [1:0] SRC_TOP  = 2'd1;
  localparam logic [1:0] SRC_END  = 2'd2;

  localparam logic [1:0] PREC_POW = 2'd3;

  typedef struct packed {
    logic       load;
    logic       push;
    logic       pop;
    logic       emit;
    logic [1:0] emit_src;
    logic       clr_drop;
  } itp_cmd_t;

  typedef struct packed {
    logic       count_nz;
    logic       top_lpar;
    logic [1:0] top_prec;
    logic [1:0] ch_prec;
    logic [2:0] ch_kind;
    logic       last;
    logic       emit_ok;
  } itp_status_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    else if (c == CH_MUL || c == CH_DIV) p = 2'd2;
    else if (c == CH_POW) p = PREC_POW;
    return p;
  endfunction

  function automatic logic [2:0] kind_of(input logic [7:0] c);
    logic [2:0] k;
    k = KIND_OPND;
    if (c == CH_LPAR) k = KIND_LPAR;
    else if (c == CH_RPAR) k = KIND_RPAR;
    else if (c == CH_POW) k = KIND_CARET;
    else if (c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV || c == CH_MOD)
      k = KIND_OP;
    return k;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/infix_to_prefix_operator_stack.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_prefix_operator_stack
// Operator-stack stage of a shunting-yard infix-to-prefix converter.
// ----------------------------------------------------------------------------
// Takes one character per input beat (reversed, parentheses swapped) and emits
// the reversed prefix stream, one character per output beat. Each beat is
// accepted while idle; due stack entries are then popped and emitted, and the
// character is emitted, pushed or, for ')', matched by popping '('. A beat
// with in_last set is followed by a flush of all held entries and the end
// marker (out_char 0, out_is_end 1). The stack holds 32 entries; a push into a
// full stack is dropped and out_overflow stays high on every output beat
// through the next end marker. Output backpressure stalls the sequencer.
// ----------------------------------------------------------------------------
module infix_to_prefix_operator_stack (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [7:0] in_char,
  input  wire        in_last,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_char,
  output logic       out_is_end,
  output logic       out_overflow
);

  itp_pkg::itp_cmd_t    cmd;
  itp_pkg::itp_status_t st;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  itp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_char      (in_char),
    .in_last      (in_last),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_is_end   (out_is_end),
    .out_overflow (out_overflow)
  );

endmodule
`default_nettype wire

@@ hw/rtl/itp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itp_ctrl
// Sequencer: steps one character through pops, push, emit and final flush.
// ----------------------------------------------------------------------------
module itp_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire itp_pkg::itp_status_t st,
  output itp_pkg::itp_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WORK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic [1:0] done_state;

  assign in_ready   = (state_r == S_IDLE);
  assign done_state = st.last ? S_FLUSH : S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WORK;
        end
      end
      S_WORK: begin
        case (st.ch_kind)
          itp_pkg::KIND_OPND: begin
            if (st.emit_ok) begin
              cmd.emit     = 1'b1;
              cmd.emit_src = itp_pkg::SRC_CHAR;
              state_nxt    = done_state;
            end
          end
          itp_pkg::KIND_LPAR: begin
            cmd.push  = 1'b1;
            state_nxt = done_state;
          end
          itp_pkg::KIND_RPAR: begin
            if (st.count_nz && !st.top_lpar) begin
              if (st.emit_ok) begin
                cmd.pop      = 1'b1;
                cmd.emit     = 1'b1;
                cmd.emit_src = itp_pkg::SRC_TOP;
              end
            end else begin
              cmd.pop   = st.count_nz;
              state_nxt = done_state;
            end
          end
          itp_pkg::KIND_CARET: begin
            if (st.count_nz && st.top_prec == itp_pkg::PREC_POW) begin
              if (st.emit_ok) begin
                cmd.pop      = 1'b1;
                cmd.emit     = 1'b1;
                cmd.emit_src = itp_pkg::SRC_TOP;
              end
            end else begin
              cmd.push  = 1'b1;
              state_nxt = done_state;
            end
          end
          itp_pkg::KIND_OP: begin
            if (st.count_nz && st.ch_prec < st.top_prec) begin
              if (st.emit_ok) begin
                cmd.pop      = 1'b1;
                cmd.emit     = 1'b1;
                cmd.emit_src = itp_pkg::SRC_TOP;
              end
            end else begin
              cmd.push  = 1'b1;
              state_nxt = done_state;
            end
          end
          default: begin
            state_nxt = done_state;
          end
        endcase
      end
      S_FLUSH: begin
        if (st.emit_ok) begin
          cmd.emit = 1'b1;
          if (st.count_nz) begin
            cmd.pop      = 1'b1;
            cmd.emit_src = itp_pkg::SRC_TOP;
          end else begin
            cmd.emit_src = itp_pkg::SRC_END;
            cmd.clr_drop = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/itp_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itp_dp
// Datapath: character latch, operator stack, drop flag and output register.
// ----------------------------------------------------------------------------
module itp_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire  [7:0]           in_char,
  input  wire                  in_last,
  input  wire itp_pkg::itp_cmd_t cmd,
  output itp_pkg::itp_status_t st,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [7:0]           out_char,
  output logic                 out_is_end,
  output logic                 out_overflow
);

  logic [7:0]                  stack_r [itp_pkg::STACK_DEPTH];
  logic [itp_pkg::CNT_W-1:0]   count_r;
  logic [itp_pkg::CNT_W-1:0]   count_nxt;
  logic [itp_pkg::CNT_W-1:0]   top_pos;
  logic [itp_pkg::PTR_W-1:0]   top_idx;
  logic [itp_pkg::PTR_W-1:0]   wr_idx;
  logic                        full;
  logic [7:0]                  top_char;
  logic [7:0]                  char_r;
  logic                        last_r;
  logic                        drop_r;
  logic                        drop_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [7:0]                  out_char_r;
  logic [7:0]                  out_char_nxt;
  logic                        out_end_r;
  logic                        out_end_nxt;
  logic                        out_ovf_r;
  logic                        out_ovf_nxt;

  assign full     = (count_r == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
  assign top_pos  = count_r - itp_pkg::CNT_W'(1);
  assign top_idx  = top_pos[itp_pkg::PTR_W-1:0];
  assign wr_idx   = count_r[itp_pkg::PTR_W-1:0];
  assign top_char = stack_r[top_idx];

  assign st.count_nz = (count_r != '0);
  assign st.top_lpar = (top_char == itp_pkg::CH_LPAR);
  assign st.top_prec = itp_pkg::prec_of(top_char);
  assign st.ch_prec  = itp_pkg::prec_of(char_r);
  assign st.ch_kind  = itp_pkg::kind_of(char_r);
  assign st.last     = last_r;
  assign st.emit_ok  = !out_valid_r || out_ready;

  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    if (cmd.push) begin
      if (full) drop_nxt = 1'b1;
      else count_nxt = count_r + itp_pkg::CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = top_pos;
    end
    if (cmd.clr_drop) drop_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_end_nxt   = out_end_r;
    out_ovf_nxt   = out_ovf_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_ovf_nxt   = drop_r;
      case (cmd.emit_src)
        itp_pkg::SRC_CHAR: begin
          out_char_nxt = char_r;
          out_end_nxt  = 1'b0;
        end
        itp_pkg::SRC_TOP: begin
          out_char_nxt = top_char;
          out_end_nxt  = 1'b0;
        end
        itp_pkg::SRC_END: begin
          out_char_nxt = 8'd0;
          out_end_nxt  = 1'b1;
        end
        default: begin
          out_char_nxt = 8'd0;
          out_end_nxt  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      stack_r[wr_idx] <= char_r;
    end
    if (cmd.load) begin
      char_r <= in_char;
      last_r <= in_last;
    end
    out_char_r <= out_char_nxt;
    out_end_r  <= out_end_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_is_end   = out_end_r;
  assign out_overflow = out_ovf_r;

endmodule
`default_nettype wire
